[rtl/core/sis_pkg.sv]
package sis_pkg;

  localparam int SIS_CAPACITY = 64;
  localparam int SIS_ID_BITS  = 40;
  localparam int VID_W        = 40;
  localparam int MODE_W       = 2;
  localparam int FIELD_CNT_W  = 7;
  localparam int STATUS_W     = 2;
  localparam int OUT_DATA_W   = 64;

  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPLIT  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_MISS   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HIT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MID    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TAIL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd0;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INS,
    CELL_DEL
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_RES,
    S_SPL
  } state_t;

endpackage

[rtl/core/sis_cell.sv]
module sis_cell #(
  parameter int IDX     = 0,
  parameter int ID_BITS = 40,
  parameter int CNT_W   = 7
) (
  input  logic                clk,
  input  sis_pkg::cell_op_t   op,
  input  logic [ID_BITS-1:0]  key,
  input  logic [CNT_W-1:0]    count,
  input  logic                prev_lt,
  input  logic [ID_BITS-1:0]  prev_id,
  input  logic [ID_BITS-1:0]  next_id,
  output logic [ID_BITS-1:0]  id,
  output logic                lt,
  output logic                eq
);
  import sis_pkg::*;

  logic [ID_BITS-1:0] id_r, id_nxt;
  logic               lt_r, eq_r;
  logic               valid;

  assign valid = CNT_W'(IDX) < count;

  always_comb begin
    id_nxt = id_r;
    case (op)
      CELL_INS: begin
        if (!lt_r) id_nxt = prev_lt ? key : prev_id;
      end
      CELL_DEL: begin
        if (!lt_r) id_nxt = next_id;
      end
      default: id_nxt = id_r;
    endcase
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    if (op == CELL_CMP) begin
      lt_r <= valid && (id_r < key);
      eq_r <= valid && (id_r == key);
    end
  end

  assign id = id_r;
  assign lt = lt_r;
  assign eq = eq_r;

endmodule

[rtl/core/sorted_id_set_node.sv]
// Search, insert, delete and a split of fewer than two ids: after the input word is taken,
// the node compares in every cell, shifts, then loads the output and raises out_tvalid.
// Split of n ids: n/2 words follow the compare, one word per cycle while out_tready is high.
// A new input word is taken only after the last result word is loaded; out_tready low adds stalls.
// Reset (rst_n low, synchronous) empties the node; stored ids are not cleared.
module sorted_id_set_node #(
  parameter int CAPACITY = sis_pkg::SIS_CAPACITY,
  parameter int ID_BITS  = sis_pkg::SIS_ID_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sis_pkg::VID_W-1:0]     in_tdata,   // [39:0] vertex_id
  input  logic [sis_pkg::MODE_W-1:0]    in_tuser,   // [1:0] mode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sis_pkg::OUT_DATA_W-1:0] out_tdata, // status, found, position,
                                                    // count_after, id_out
  output logic                          out_tlast
);
  import sis_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t state_r, state_nxt;

  logic [MODE_W-1:0]   mode_r;
  logic [ID_BITS-1:0]  key_r;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    keep_r, split_idx_r;
  logic [STATUS_W-1:0] res_status_r;
  logic                res_found_r;
  logic [CNT_W-1:0]    res_pos_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_found_r;
  logic [CNT_W-1:0]    out_pos_r, out_cnt_r;
  logic [ID_BITS-1:0]  out_id_r;
  logic                out_last_r;

  cell_op_t            cell_op;
  logic [ID_BITS-1:0]  cell_id [CAPACITY];
  logic [CAPACITY-1:0] cell_lt, cell_eq;

  logic [63:0]         key_ext;
  logic                out_free;
  logic                found_w;
  logic [CNT_W-1:0]    pos_w, move_w, sel_idx;
  logic [ID_BITS-1:0]  sel_id;
  logic [STATUS_W-1:0] status_w;
  logic                take_in, load_res, load_spl, spl_last, split_start;

  assign key_ext  = {{(64 - VID_W){1'b0}}, in_tdata};
  assign out_free = !out_valid_r || out_tready;
  assign take_in  = in_tvalid && in_tready;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      sis_cell #(
        .IDX     (g),
        .ID_BITS (ID_BITS),
        .CNT_W   (CNT_W)
      ) u_cell (
        .clk     (clk),
        .op      (cell_op),
        .key     (key_r),
        .count   (count_r),
        .prev_lt ((g == 0) ? 1'b1 : cell_lt[(g == 0) ? 0 : g - 1]),
        .prev_id ((g == 0) ? key_r : cell_id[(g == 0) ? 0 : g - 1]),
        .next_id ((g == CAPACITY - 1) ? cell_id[g] : cell_id[(g == CAPACITY - 1) ? g : g + 1]),
        .id      (cell_id[g]),
        .lt      (cell_lt[g]),
        .eq      (cell_eq[g])
      );
    end
  endgenerate

  // thermometer of "below key" to index of the first cell not below it
  always_comb begin
    pos_w = '0;
    if (!cell_lt[0]) pos_w = '0;
    for (int i = 1; i < CAPACITY; i++) begin
      if (cell_lt[i-1] && !cell_lt[i]) pos_w = pos_w | CNT_W'(i);
    end
    if (cell_lt[CAPACITY-1]) pos_w = CNT_W'(CAPACITY);
  end

  assign found_w = |cell_eq;
  assign move_w  = count_r >> 1;

  always_comb begin
    sel_idx = (state_r == S_SPL) ? split_idx_r :
              ((count_r == '0) ? '0 : count_r - CNT_W'(1));
    sel_id  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CNT_W'(i) == sel_idx) sel_id = sel_id | cell_id[i];
    end
    if (count_r == '0 && state_r != S_SPL) sel_id = '0;
  end

  always_comb begin
    status_w = ST_MISS;
    unique case (mode_r)
      MODE_SEARCH: status_w = found_w ? ST_HIT : ST_MISS;
      MODE_INSERT: begin
        if (found_w) status_w = ST_DUP;
        else if (count_r >= CNT_W'(CAPACITY)) status_w = ST_FULL;
        else status_w = (pos_w == count_r) ? ST_TAIL : ST_MID;
      end
      MODE_DELETE: begin
        if (!found_w) status_w = ST_ABSENT;
        else status_w = (pos_w + CNT_W'(1) == count_r) ? ST_TAIL : ST_MID;
      end
      default: status_w = ST_MISS;
    endcase
  end

  assign spl_last = split_idx_r == count_r - CNT_W'(1);

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cell_op     = CELL_HOLD;
    count_nxt   = count_r;
    load_res    = 1'b0;
    load_spl    = 1'b0;
    split_start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = S_CMP;
      end
      S_CMP: begin
        cell_op   = CELL_CMP;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        state_nxt = S_RES;
        if (mode_r == MODE_INSERT && !found_w && count_r < CNT_W'(CAPACITY)) begin
          cell_op   = CELL_INS;
          count_nxt = count_r + CNT_W'(1);
        end else if (mode_r == MODE_DELETE && found_w) begin
          cell_op   = CELL_DEL;
          count_nxt = count_r - CNT_W'(1);
        end else if (mode_r == MODE_SPLIT && move_w != '0) begin
          split_start = 1'b1;
          state_nxt   = S_SPL;
        end
      end
      S_RES: begin
        if (out_free) begin
          load_res  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SPL: begin
        if (out_free) begin
          load_spl = 1'b1;
          if (spl_last) begin
            count_nxt = keep_r;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (load_res || load_spl) out_valid_r <= 1'b1;
      else if (out_tready)      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      mode_r <= in_tuser;
      key_r  <= key_ext[ID_BITS-1:0];
    end
    if (state_r == S_UPD) begin
      res_found_r  <= (mode_r == MODE_SPLIT) ? 1'b0 : found_w;
      res_pos_r    <= (mode_r == MODE_SPLIT) ? '0 : pos_w;
      res_status_r <= status_w;
    end
    if (split_start) begin
      keep_r      <= count_r - move_w;
      split_idx_r <= count_r - move_w;
    end else if (load_spl) begin
      split_idx_r <= split_idx_r + CNT_W'(1);
    end
    if (load_res) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_pos_r    <= res_pos_r;
      out_cnt_r    <= count_r;
      out_id_r     <= sel_id;
      out_last_r   <= 1'b1;
    end else if (load_spl) begin
      out_status_r <= ST_HIT;
      out_found_r  <= 1'b1;
      out_pos_r    <= split_idx_r;
      out_cnt_r    <= keep_r;
      out_id_r     <= sel_id;
      out_last_r   <= spl_last;
    end
  end

  logic [63:0] out_id_ext;
  assign out_id_ext = 64'(out_id_r);

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_id_ext[39:0], FIELD_CNT_W'(out_cnt_r),
                       FIELD_CNT_W'(out_pos_r), out_found_r, out_status_r};

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import sis_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 16;
  localparam logic [VID_W-1:0] ID_MAX   = {VID_W{1'b1}};
  localparam logic [VID_W-1:0] KEY_MASK = (SIS_ID_BITS >= VID_W) ? ID_MAX :
                                          VID_W'((64'd1 << SIS_ID_BITS) - 64'd1);

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic                   found;
    logic [FIELD_CNT_W-1:0] position;
    logic [FIELD_CNT_W-1:0] count_after;
    logic [VID_W-1:0]       id_out;
    logic                   last;
  } node_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [VID_W-1:0]      in_tdata = '0;
  logic [MODE_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned fails = 0;
  int unsigned idle_cycles = 0;

  // shadow copy of the node
  logic [VID_W-1:0] node_ids [SIS_CAPACITY];
  int unsigned      node_count = 0;
  node_result_t     pending_results[$];

  sorted_id_set_node dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void push_result(logic [STATUS_W-1:0] status, logic found,
                                      int unsigned pos, int unsigned cnt,
                                      logic [VID_W-1:0] id, logic last);
    node_result_t r;
    r.status      = status;
    r.found       = found;
    r.position    = FIELD_CNT_W'(pos);
    r.count_after = FIELD_CNT_W'(cnt);
    r.id_out      = id;
    r.last        = last;
    pending_results.push_back(r);
  endfunction

  function automatic logic [VID_W-1:0] largest_id();
    return (node_count != 0) ? node_ids[node_count-1] : '0;
  endfunction

  function automatic void predict_node_op(logic [MODE_W-1:0] mode, logic [VID_W-1:0] vid);
    logic [VID_W-1:0]    key;
    int unsigned         n;
    int unsigned         pos;
    int unsigned         keep;
    logic                hit;
    logic [STATUS_W-1:0] status;
    key = vid & KEY_MASK;
    n   = node_count;
    if (mode == MODE_SPLIT) begin
      if (n < 2) begin
        push_result(ST_MISS, 1'b0, 0, n, largest_id(), 1'b1);
      end else begin
        keep = n - n / 2;
        for (int i = keep; i < n; i++)
          push_result(ST_HIT, 1'b1, i, keep, node_ids[i], i == n - 1);
        node_count = keep;
      end
      return;
    end
    pos = 0;
    while (pos < n && node_ids[pos] < key) pos++;
    hit = (pos < n) && (node_ids[pos] == key);
    case (mode)
      MODE_SEARCH: begin
        status = hit ? ST_HIT : ST_MISS;
      end
      MODE_INSERT: begin
        if (hit) begin
          status = ST_DUP;
        end else if (n >= SIS_CAPACITY) begin
          status = ST_FULL;
        end else begin
          status = (pos == n) ? ST_TAIL : ST_MID;
          for (int i = n; i > pos; i--) node_ids[i] = node_ids[i-1];
          node_ids[pos] = key;
          node_count = n + 1;
        end
      end
      default: begin
        if (!hit) begin
          status = ST_ABSENT;
        end else begin
          status = (pos + 1 == n) ? ST_TAIL : ST_MID;
          for (int i = pos; i + 1 < n; i++) node_ids[i] = node_ids[i+1];
          node_count = n - 1;
        end
      end
    endcase
    push_result(status, hit, pos, node_count, largest_id(), 1'b1);
  endfunction

  function automatic logic [VID_W-1:0] random_vid();
    return VID_W'({$urandom, $urandom});
  endfunction

  task automatic send_word(logic [MODE_W-1:0] mode, logic [VID_W-1:0] vid);
    in_tvalid <= 1'b1;
    in_tdata  <= vid;
    in_tuser  <= mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_node_op(mode, vid);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= random_vid();
      in_tuser  <= MODE_W'($urandom);
      @(posedge clk);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_empty_node();
    send_word(MODE_SEARCH, '0);
    send_word(MODE_DELETE, ID_MAX);
    send_word(MODE_SPLIT, random_vid());
    send_word(MODE_INSERT, '0);
    send_word(MODE_SPLIT, ID_MAX);
    send_word(MODE_SEARCH, '0);
  endtask

  task automatic test_basic_ops();
    send_word(MODE_INSERT, ID_MAX);
    send_word(MODE_INSERT, 40'h55_5555_5555);
    send_word(MODE_INSERT, 40'hAA_AAAA_AAAA);
    send_word(MODE_INSERT, 40'h00_0000_0100);
    send_word(MODE_INSERT, 40'hAA_AAAA_AAAA);
    send_word(MODE_SEARCH, 40'h55_5555_5554);
    send_word(MODE_SEARCH, 40'hAA_AAAA_AAAA);
    send_word(MODE_SEARCH, ID_MAX);
    send_word(MODE_DELETE, 40'h55_5555_5555);
    send_word(MODE_DELETE, ID_MAX);
    send_word(MODE_DELETE, 40'h12_3456_789A);
    send_word(MODE_INSERT, ID_MAX - 1);
    send_word(MODE_INSERT, 40'h80_0000_0000);
    send_word(MODE_INSERT, 40'h7F_FFFF_FFFF);
    send_word(MODE_SPLIT, '0);
    send_word(MODE_SPLIT, '0);
  endtask

  task automatic test_full_node();
    logic [VID_W-1:0] lo_id;
    wait_drain();
    while (node_count < SIS_CAPACITY) send_word(MODE_INSERT, random_vid() | 40'h1);
    send_word(MODE_INSERT, '0);
    send_word(MODE_INSERT, ID_MAX - 1);
    send_word(MODE_INSERT, node_ids[SIS_CAPACITY/2]);
    send_word(MODE_SEARCH, node_ids[0]);
    lo_id = node_ids[0];
    wait_drain();
    send_word(MODE_SPLIT, '0);
    send_word(MODE_DELETE, lo_id);
    send_word(MODE_SPLIT, '0);
    send_word(MODE_SPLIT, '0);
  endtask

  task automatic test_random_mix(int unsigned items, int unsigned tx_pct, int unsigned rx_pct);
    int unsigned      r;
    logic [MODE_W-1:0] mode;
    logic [VID_W-1:0] vid;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(99);
      if (r < 48)      mode = MODE_INSERT;
      else if (r < 68) mode = MODE_SEARCH;
      else if (r < 93) mode = MODE_DELETE;
      else             mode = MODE_SPLIT;
      r = $urandom_range(99);
      if (r < 40 && node_count != 0) begin
        vid = node_ids[$urandom_range(node_count - 1)];
      end else if (r < 55 && node_count != 0) begin
        vid = node_ids[$urandom_range(node_count - 1)];
        vid = $urandom_range(1) ? vid + VID_W'(1) : vid - VID_W'(1);
      end else if (r < 63) begin
        vid = $urandom_range(1) ? ID_MAX - VID_W'($urandom_range(1)) : VID_W'($urandom_range(1));
      end else begin
        vid = random_vid();
      end
      send_word(mode, vid);
    end
  endtask

  task automatic check_field(string name, logic [63:0] expv, logic [63:0] act);
    if (expv !== act) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, act);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    node_result_t expr;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h last %b",
                 $time, out_tdata, out_tlast);
        fails++;
      end else begin
        expr = pending_results.pop_front();
        check_field("status", expr.status, out_tdata[1:0]);
        check_field("found", expr.found, out_tdata[2]);
        check_field("position", expr.position, out_tdata[9:3]);
        check_field("count_after", expr.count_after, out_tdata[16:10]);
        check_field("id_out", expr.id_out, out_tdata[56:17]);
        check_field("padding", '0, out_tdata[63:57]);
        check_field("last", expr.last, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 32;
    rx_idle_pct = 60;
    test_empty_node();
    test_basic_ops();
    test_full_node();
    test_random_mix(52, 32, 60);
    test_random_mix(52, 60, 32);
    wait_drain();
    test_random_mix(54, 0, 0);
    wait_drain();
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
